@@ hw/rtl/zrle_pkg.sv @@
// Zero-run-length encoder: shared types and constants.
// Used by zrle_front, zrle_queue, zrle_back and zero_run_length_encoder.

package zrle_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] RUN_LIMIT = 8'hFD;

   localparam int NUM_SLOTS = 9;

   localparam int SLOT_LEN0  = 0;
   localparam int SLOT_LEN1  = 1;
   localparam int SLOT_LEN2  = 2;
   localparam int SLOT_LEN3  = 3;
   localparam int SLOT_FMARK = 4;
   localparam int SLOT_FRUN  = 5;
   localparam int SLOT_LIT   = 6;
   localparam int SLOT_CMARK = 7;
   localparam int SLOT_CRUN  = 8;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        block_end;
      logic [31:0] block_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       block_done;
   } rsp_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic [31:0]          length;
      logic [7:0]           flush_run;
      logic [7:0]           literal;
      logic [7:0]           close_run;
   } job_type;

endpackage

@@ hw/rtl/zrle_front.sv @@
// Front end: accepts requests, tracks block and zero-run state, builds jobs.
// Depends on zrle_pkg.

module zrle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  zrle_pkg::req_type req_data,
   output logic              push,
   output zrle_pkg::job_type push_job
);

   logic       inside_ff, inside_in;
   logic [7:0] run_ff, run_in;
   logic [7:0] run_start;
   logic [7:0] run_mid;
   logic       do_flush;
   logic [7:0] flush_run;
   logic       is_literal;

   always_comb begin
      run_start  = inside_ff ? run_ff : 8'd0;
      do_flush   = 1'b0;
      flush_run  = run_start;
      is_literal = 1'b0;
      run_mid    = 8'd0;
      if (req_data.data_byte != 8'd0) begin
         do_flush   = (run_start != 8'd0);
         is_literal = 1'b1;
      end else if (run_start < zrle_pkg::RUN_LIMIT) begin
         run_mid = run_start + 8'd1;
      end else begin
         do_flush  = 1'b1;
         flush_run = run_start + 8'd1;
      end
   end

   always_comb begin
      push_job.slots = '0;
      push_job.slots[zrle_pkg::SLOT_LEN0]  = !inside_ff;
      push_job.slots[zrle_pkg::SLOT_LEN1]  = !inside_ff;
      push_job.slots[zrle_pkg::SLOT_LEN2]  = !inside_ff;
      push_job.slots[zrle_pkg::SLOT_LEN3]  = !inside_ff;
      push_job.slots[zrle_pkg::SLOT_FMARK] = do_flush;
      push_job.slots[zrle_pkg::SLOT_FRUN]  = do_flush;
      push_job.slots[zrle_pkg::SLOT_LIT]   = is_literal;
      push_job.slots[zrle_pkg::SLOT_CMARK] = req_data.block_end;
      push_job.slots[zrle_pkg::SLOT_CRUN]  = req_data.block_end;
      push_job.length    = req_data.block_length;
      push_job.flush_run = flush_run;
      push_job.literal   = req_data.data_byte;
      push_job.close_run = run_mid;
   end

   assign push = req_fire && (push_job.slots != '0);

   always_comb begin
      inside_in = inside_ff;
      run_in    = run_ff;
      if (req_fire) begin
         inside_in = !req_data.block_end;
         run_in    = req_data.block_end ? 8'd0 : run_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         run_ff    <= 8'd0;
      end else begin
         inside_ff <= inside_in;
         run_ff    <= run_in;
      end
   end

endmodule

@@ hw/rtl/zrle_queue.sv @@
// Job queue between front and back end, built from flip-flops.
// Depends on zrle_pkg for the job type.

module zrle_queue #(
   parameter int DEPTH = zrle_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  zrle_pkg::job_type push_job,
   input  logic              pop,
   output zrle_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   zrle_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/zrle_back.sv @@
// Back end: walks each job's output slots and drives the response register.
// Depends on zrle_pkg.

module zrle_back (
   input  logic              clock,
   input  logic              reset,
   input  zrle_pkg::job_type head_job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zrle_pkg::rsp_type rsp_data
);

   zrle_pkg::job_type                cur_ff, cur_in;
   logic [zrle_pkg::NUM_SLOTS-1:0]   mask_ff, mask_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   zrle_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   zrle_pkg::job_type                work;
   logic                             have_work;
   logic                             use_head;
   logic                             slot_free;
   logic                             fire;
   logic [zrle_pkg::NUM_SLOTS-1:0]   low;
   logic [zrle_pkg::NUM_SLOTS-1:0]   remain;
   logic [7:0]                       sel_byte;

   assign use_head  = (mask_ff == '0);
   assign work      = use_head ? head_job : cur_ff;
   assign have_work = use_head ? !empty : 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fire      = have_work && slot_free;
   assign pop       = fire && use_head;
   assign low       = work.slots & (~work.slots + 1'b1);
   assign remain    = work.slots & ~low;

   always_comb begin
      case (1'b1)
         low[zrle_pkg::SLOT_LEN0]:  sel_byte = work.length[7:0];
         low[zrle_pkg::SLOT_LEN1]:  sel_byte = work.length[15:8];
         low[zrle_pkg::SLOT_LEN2]:  sel_byte = work.length[23:16];
         low[zrle_pkg::SLOT_LEN3]:  sel_byte = work.length[31:24];
         low[zrle_pkg::SLOT_FMARK]: sel_byte = 8'd0;
         low[zrle_pkg::SLOT_FRUN]:  sel_byte = work.flush_run;
         low[zrle_pkg::SLOT_LIT]:   sel_byte = work.literal;
         low[zrle_pkg::SLOT_CMARK]: sel_byte = 8'd0;
         low[zrle_pkg::SLOT_CRUN]:  sel_byte = work.close_run;
         default:                   sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = have_work;
      end
      if (fire) begin
         cur_in                   = work;
         cur_in.slots             = remain;
         mask_in                  = remain;
         rsp_data_in.out_byte     = sel_byte;
         rsp_data_in.last_of_item = (remain == '0);
         rsp_data_in.block_done   = low[zrle_pkg::SLOT_CRUN];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/zero_run_length_encoder.sv @@
// Zero-run-length encoder, top level: front end, job queue, back end.
// Depends on zrle_pkg, zrle_front, zrle_queue and zrle_back.
//
// One raw byte is taken per cycle whenever the job queue (QUEUE_DEPTH
// entries) has room; the back end sends one coded byte per cycle, unless
// rsp_stall holds it, through a registered output. A request yields 0 to 7
// coded bytes: a stream of literals or zeros runs at one request per cycle
// while the output is not stalled, whereas block headers (4 bytes), run
// flushes (2 bytes) and closing pairs (2 bytes) are absorbed by the queue
// and slow the input only once it fills. The first byte of a block emits
// its length as a 4-byte little-endian header; zero runs are coded as 0x00
// followed by the run count, capped at 254; every block ends with a closing
// 0x00, run pair whose run byte is flagged by block_done.

module zero_run_length_encoder #(
   parameter int QUEUE_DEPTH = zrle_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zrle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zrle_pkg::rsp_type rsp_data
);

   logic              req_fire;
   logic              push;
   logic              pop;
   logic              empty;
   logic              full;
   zrle_pkg::job_type push_job;
   zrle_pkg::job_type head_job;

   assign req_stall = full;
   assign req_fire  = req_valid && !full;

   zrle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .push     (push),
      .push_job (push_job)
   );

   zrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   zrle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/zero_run_length_encoder_tb.sv @@
// Testbench for zero_run_length_encoder: directed table, then random blocks,
// every coded byte checked against typed table bytes or an in-bench coder.
// Depends on zrle_pkg and the zero_run_length_encoder RTL.
`timescale 1ns / 100ps

module zero_run_length_encoder_tb;

   localparam int PERIOD = 8;
   localparam int RANDOM_ITEMS = 310;
   localparam int DRAIN_LIMIT = 20000;
   localparam logic [7:0] ZERO_MARK = 8'h00;

   typedef struct packed {
      zrle_pkg::req_type req;
      logic [3:0]        n_typed;
      logic [71:0]       coded;
   } stim_type;

   localparam int NUM_DIRECTED = 18;
   localparam stim_type DIRECTED [NUM_DIRECTED] = '{
      '{'{8'hFF, 1'b1, 32'hFFFF_FFFF}, 4'd7,
        {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h0}},
      '{'{8'h00, 1'b1, 32'h0000_0000}, 4'd6,
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 24'h0}},
      '{'{8'h01, 1'b1, 32'h0000_0001}, 4'd7,
        {8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 16'h0}},
      '{'{8'h80, 1'b0, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h01, 1'b0, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h7F, 1'b1, 32'h0000_0003}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h1234_5678}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h1234_5678}, 4'd0, 72'd0},
      '{'{8'h55, 1'b0, 32'h1234_5678}, 4'd0, 72'd0},
      '{'{8'h00, 1'b1, 32'h1234_5678}, 4'd0, 72'd0},
      '{'{8'h01, 1'b0, 32'hA5A5_A5A5}, 4'd0, 72'd0},
      '{'{8'hFE, 1'b1, 32'hA5A5_A5A5}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h5A5A_5A5A}, 4'd0, 72'd0},
      '{'{8'h00, 1'b0, 32'h5A5A_5A5A}, 4'd0, 72'd0},
      '{'{8'h00, 1'b1, 32'h5A5A_5A5A}, 4'd0, 72'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   zrle_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   zrle_pkg::rsp_type rsp_data;

   logic              open_block;
   logic [7:0]        zero_count;
   zrle_pkg::rsp_type fresh_q[$];
   zrle_pkg::rsp_type coded_q[$];
   stim_type          row_q[$];
   int unsigned fail_count = 0;
   int          stall_left = 0;
   bit          steady = 1'b0;

   zero_run_length_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void emit(logic [7:0] value, logic done);
      fresh_q.push_back('{value, 1'b0, done});
   endfunction

   function automatic void code_request(zrle_pkg::req_type r);
      if (!open_block) begin
         for (int k = 0; k < 4; k++) emit(r.block_length[8*k +: 8], 1'b0);
         open_block = 1'b1;
         zero_count = '0;
      end
      if (r.data_byte != 8'h00) begin
         if (zero_count != 0) begin
            emit(ZERO_MARK, 1'b0);
            emit(zero_count, 1'b0);
            zero_count = '0;
         end
         emit(r.data_byte, 1'b0);
      end else if (zero_count < zrle_pkg::RUN_LIMIT) begin
         zero_count = zero_count + 8'd1;
      end else begin
         emit(ZERO_MARK, 1'b0);
         emit(zero_count + 8'd1, 1'b0);
         zero_count = '0;
      end
      if (r.block_end) begin
         emit(ZERO_MARK, 1'b0);
         emit(zero_count, 1'b1);
         zero_count = '0;
         open_block = 1'b0;
      end
      if (fresh_q.size() != 0) fresh_q[fresh_q.size() - 1].last_of_item = 1'b1;
   endfunction

   function automatic void report(string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endfunction

   always @(posedge clock) begin
      stim_type          row;
      zrle_pkg::rsp_type want;
      if (reset) begin
         open_block = 1'b0;
         zero_count = '0;
         coded_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            row = row_q.pop_front();
            fresh_q.delete();
            code_request(req_data);
            if (row.n_typed != 0) begin
               fresh_q.delete();
               for (int k = 0; k < row.n_typed; k++)
                  fresh_q.push_back('{row.coded[71 - 8*k -: 8], k == row.n_typed - 1,
                                      k == row.n_typed - 1 && row.req.block_end});
            end
            foreach (fresh_q[k]) coded_q.push_back(fresh_q[k]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (coded_q.size() == 0) begin
               report($sformatf("unexpected byte %h last %b done %b", rsp_data.out_byte,
                                rsp_data.last_of_item, rsp_data.block_done));
            end else begin
               want = coded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte
                   || rsp_data.last_of_item !== want.last_of_item
                   || rsp_data.block_done !== want.block_done)
                  report($sformatf("byte %h/%h last %b/%b done %b/%b (got/expected)",
                                   rsp_data.out_byte, want.out_byte,
                                   rsp_data.last_of_item, want.last_of_item,
                                   rsp_data.block_done, want.block_done));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input stim_type row);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row_q.push_back(row);
      req_valid <= 1'b1;
      req_data <= row.req;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_block(input int unsigned size, input int unsigned zero_pct,
                             input bit honest);
      zrle_pkg::req_type r;
      logic [31:0]       declared;
      declared = honest ? 32'(size) : 32'($urandom);
      for (int unsigned k = 0; k < size; k++) begin
         r.data_byte = ($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                          : 8'($urandom_range(1, 255));
         r.block_end = (k == size - 1);
         r.block_length = declared;
         send_request('{r, 4'd0, 72'd0});
      end
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && coded_q.size() != 0; n++) @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned size;
      int unsigned roll;
      bit          long_done;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED[k]) send_request(DIRECTED[k]);
      // hold off until every coded byte of the table has arrived or DRAIN_LIMIT runs out
      await_drain();
      sent = 0;
      long_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         if (!long_done && sent >= 40) begin
            // full run of zeros that completes on the final byte
            send_block(254, 100, 1'b1);
            sent += 254;
            long_done = 1'b1;
         end else begin
            roll = $urandom_range(0, 9);
            size = (roll < 6) ? $urandom_range(1, 6)
                 : (roll < 9) ? $urandom_range(7, 20) : $urandom_range(21, 60);
            roll = $urandom_range(0, 2);
            send_block(size, (roll == 0) ? 20 : (roll == 1) ? 50 : 85,
                       $urandom_range(0, 3) != 0);
            sent += size;
         end
      end
      await_drain();
      repeat (20) @(posedge clock);
      if (coded_q.size() != 0)
         report($sformatf("%0d coded bytes never arrived", coded_q.size()));
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
